/* src/sie_pkg.sv */
// shared types and constants for the switch input edge action block
// no dependencies
`default_nettype none

package sie_pkg;

  localparam int unsigned ActionW   = 9;
  localparam int unsigned UsageW    = 16;
  localparam int unsigned DelayW    = 26;
  localparam int unsigned ChanW     = 5;
  localparam int unsigned ObjNumW   = 8;
  localparam int unsigned ObjValW   = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 26;

  // edge action codes
  localparam logic [ActionW-1:0] ACT_ON_RISE   = 9'h000;
  localparam logic [ActionW-1:0] ACT_TOG_RISE  = 9'h001;
  localparam logic [ActionW-1:0] ACT_ON_FALL   = 9'h002;
  localparam logic [ActionW-1:0] ACT_TOG_FALL  = 9'h003;
  localparam logic [ActionW-1:0] ACT_STATE     = 9'h005;
  localparam logic [ActionW-1:0] ACT_ON_DELAY  = 9'h008;
  localparam logic [ActionW-1:0] ACT_OFF_DELAY = 9'h009;
  localparam logic [ActionW-1:0] ACT_GROUP_ON  = 9'h00C;
  localparam logic [ActionW-1:0] ACT_GROUP_OFF = 9'h00D;
  localparam logic [ActionW-1:0] ACT_VAL_RISE  = 9'h100;
  localparam logic [ActionW-1:0] ACT_VAL_FALL  = 9'h102;
  localparam logic [ActionW-1:0] ACT_VAL_ANY   = 9'h104;

  // request kinds
  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ACTION_CODE   = 3'd0,
    REG_RISING_USAGE  = 3'd1,
    REG_FALLING_USAGE = 3'd2,
    REG_DELAY_MS      = 3'd3,
    REG_CHANNEL_INDEX = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [ActionW-1:0] action_code;
    logic [UsageW-1:0]  rising_usage;
    logic [UsageW-1:0]  falling_usage;
    logic [DelayW-1:0]  delay_ms;
    logic [ChanW-1:0]   channel_index;
  } cfg_t;

  typedef struct packed {
    logic [ObjValW-1:0] own_value;
    logic               tmr_running;
    logic [DelayW-1:0]  tmr_remaining;
  } chan_state_t;

  typedef struct packed {
    logic               emit;
    logic [ObjNumW-1:0] object_number;
    logic [ObjValW-1:0] object_value;
  } result_t;

endpackage

`default_nettype wire

/* src/sie_cfg_regs.sv */
// configuration register file of the switch input edge action block
// depends on sie_pkg
`default_nettype none

module sie_cfg_regs
  import sie_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_ACTION_CODE:   cfg_r.action_code   <= cfg_wdata[ActionW-1:0];
        REG_RISING_USAGE:  cfg_r.rising_usage  <= cfg_wdata[UsageW-1:0];
        REG_FALLING_USAGE: cfg_r.falling_usage <= cfg_wdata[UsageW-1:0];
        REG_DELAY_MS:      cfg_r.delay_ms      <= cfg_wdata[DelayW-1:0];
        REG_CHANNEL_INDEX: cfg_r.channel_index <= cfg_wdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/sie_action.sv */
// action decode: result and next channel state for one request
// depends on sie_pkg
`default_nettype none

module sie_action
  import sie_pkg::*;
(
  input  cfg_t        cfg,
  input  wire logic   op,
  input  wire logic   level,
  input  wire logic   long_press,
  input  chan_state_t cur,
  output result_t     res,
  output chan_state_t nxt
);

  logic [ObjNumW-1:0] own_obj;
  logic [ObjNumW-1:0] grp_obj;
  logic               emit;
  logic [ObjNumW-1:0] obj;
  logic [ObjValW-1:0] val;
  logic               start;

  assign own_obj = ObjNumW'({3'b000, cfg.channel_index} * 8'd5);
  assign grp_obj = ObjNumW'({4'b0000, cfg.channel_index[ChanW-1:1]} * 8'd10);

  always_comb begin
    emit  = 1'b0;
    obj   = own_obj;
    val   = '0;
    start = 1'b0;
    nxt   = cur;

    if (op == OP_TICK) begin
      if (cur.tmr_running) begin
        if (cur.tmr_remaining > DelayW'(1)) begin
          nxt.tmr_remaining = cur.tmr_remaining - DelayW'(1);
        end else begin
          nxt.tmr_running   = 1'b0;
          nxt.tmr_remaining = '0;
          case (cfg.action_code)
            ACT_ON_DELAY:  begin emit = 1'b1; val = ObjValW'(1); end
            ACT_OFF_DELAY: begin emit = 1'b1; end
            ACT_STATE: begin
              // cyclic repeat of the own object
              emit  = 1'b1;
              val   = cur.own_value;
              start = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end else if (!long_press) begin
      if (level) begin
        case (cfg.action_code)
          ACT_ON_RISE: begin
            emit = 1'b1;
            val  = ObjValW'(cfg.rising_usage != '0);
          end
          ACT_TOG_RISE: begin
            emit = 1'b1;
            val  = ObjValW'(cur.own_value == '0);
          end
          ACT_GROUP_ON:  begin emit = 1'b1; obj = grp_obj; val = ObjValW'(1); end
          ACT_GROUP_OFF: begin emit = 1'b1; obj = grp_obj; end
          ACT_STATE: begin
            emit  = 1'b1;
            val   = cfg.rising_usage;
            start = (cfg.delay_ms != '0);
          end
          ACT_ON_DELAY:  start = 1'b1;
          ACT_OFF_DELAY: begin emit = 1'b1; val = ObjValW'(1); end
          ACT_VAL_RISE, ACT_VAL_ANY: begin
            emit = 1'b1;
            val  = {8'h00, cfg.rising_usage[7:0]};
          end
          default: ;
        endcase
      end else begin
        case (cfg.action_code)
          ACT_ON_FALL: begin
            emit = 1'b1;
            val  = ObjValW'(cfg.falling_usage != '0);
          end
          ACT_TOG_FALL: begin
            emit = 1'b1;
            val  = ObjValW'(cur.own_value == '0);
          end
          ACT_STATE: begin
            emit  = 1'b1;
            val   = cfg.falling_usage;
            start = (cfg.delay_ms != '0);
          end
          ACT_ON_DELAY:  emit = 1'b1;
          ACT_OFF_DELAY: start = 1'b1;
          ACT_VAL_FALL, ACT_VAL_ANY: begin
            emit = 1'b1;
            val  = {8'h00, cfg.falling_usage[7:0]};
          end
          default: ;
        endcase
      end
    end

    if (start) begin
      nxt.tmr_running   = 1'b1;
      nxt.tmr_remaining = cfg.delay_ms;
    end
    // group write on an even channel lands on the own object too
    if (emit && (obj == own_obj)) begin
      nxt.own_value = val;
    end

    res.emit          = emit;
    res.object_number = obj;
    res.object_value  = val;
  end

endmodule

`default_nettype wire

/* src/switch_input_edge_action.sv */
// top level of the switch input edge action block: request register, action
// decode and result register; depends on sie_pkg, sie_cfg_regs, sie_action
`default_nettype none

// One binary input channel of a switch actuator. A request is either an
// input level change (op 0, with level and long-press flag) or a one
// millisecond tick (op 1). Each request gives at most one object write on
// the out_ channel. A request is registered, decoded and its result
// registered, so one request is taken every clock while the output is
// not stalled. Requests that write nothing produce no result.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
module switch_input_edge_action
  import sie_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_op,
  input  wire logic                 in_level,
  input  wire logic                 in_long_press,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ObjNumW-1:0]        out_object_number,
  output logic [ObjValW-1:0]        out_object_value
);

  cfg_t        cfg;
  chan_state_t state_r;
  chan_state_t state_nxt;
  result_t     res;

  logic               req_valid_r;
  logic               req_op_r;
  logic               req_level_r;
  logic               req_long_press_r;
  logic               out_valid_r;
  logic [ObjNumW-1:0] out_obj_r;
  logic [ObjValW-1:0] out_val_r;
  logic               advance;
  logic               in_take;

  sie_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sie_action u_action (
    .cfg        (cfg),
    .op         (req_op_r),
    .level      (req_level_r),
    .long_press (req_long_press_r),
    .cur        (state_r),
    .res        (res),
    .nxt        (state_nxt)
  );

  // result register is free or being emptied this cycle
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= req_valid_r && res.emit;
      end
      if (advance && req_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op_r         <= in_op;
      req_level_r      <= in_level;
      req_long_press_r <= in_long_press;
    end
    if (advance && req_valid_r && res.emit) begin
      out_obj_r <= res.object_number;
      out_val_r <= res.object_value;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_object_number = out_obj_r;
  assign out_object_value  = out_val_r;

endmodule

`default_nettype wire

/* src/sie_checker.sv */
// port-level checks for switch_input_edge_action, with its bind
// depends on sie_pkg
`default_nettype none

module sie_checker
  import sie_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [ObjNumW-1:0] out_object_number,
  input wire logic [ObjValW-1:0] out_object_value
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_object_number)
      && $stable(out_object_value))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // object numbers stay within the channel and group range
  a_obj_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_object_number <= 8'd160)
    else $error("object number out of range");

  // the input side only stalls when the result side does
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled without output backpressure");

endmodule

bind switch_input_edge_action sie_checker u_sie_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_object_number (out_object_number),
  .out_object_value  (out_object_value)
);

`default_nettype wire

/* tb/tb_switch_input_edge_action.sv */
// self-checking testbench for switch_input_edge_action: directed and random requests,
// randomised register settings, a built-in model of the edge actions and delay timer
// depends on sie_pkg and the switch_input_edge_action RTL
module tb_switch_input_edge_action;
  import sie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalRequests = 1350;
  localparam int QuietCycles   = 6;      // idle cycles before a register write
  localparam int TailItems     = 150;    // no idling once this few entries remain
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 400000;
  localparam int MaxPrinted    = 50;

  typedef enum logic {ENT_REQ, ENT_CFG} ent_kind_t;

  typedef struct {
    ent_kind_t            kind;
    logic                 op;
    logic                 level;
    logic                 long_press;
    reg_index_t           reg_idx;
    logic [CfgDataW-1:0]  data;
  } pending_ent_t;

  typedef struct {
    logic [ObjNumW-1:0] number;
    logic [ObjValW-1:0] value;
  } obj_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = 1'b0;
  logic                 in_level = 1'b0;
  logic                 in_long_press = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ObjNumW-1:0]   out_object_number;
  logic [ObjValW-1:0]   out_object_value;

  switch_input_edge_action DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_level          (in_level),
    .in_long_press     (in_long_press),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_object_number (out_object_number),
    .out_object_value  (out_object_value)
  );

  pending_ent_t pending_events[$];
  obj_write_t   due_writes[$];

  // model copy of the registers and channel state
  logic [ActionW-1:0] cfg_action   = '0;
  logic [UsageW-1:0]  cfg_rising   = '0;
  logic [UsageW-1:0]  cfg_falling  = '0;
  logic [DelayW-1:0]  cfg_delay    = '0;
  logic [ChanW-1:0]   cfg_chan     = '0;
  logic [ObjValW-1:0] own_value    = '0;
  logic               timer_on     = 1'b0;
  logic [DelayW-1:0]  timer_left   = '0;

  logic [ActionW-1:0] action_codes [12] = '{
    ACT_ON_RISE, ACT_TOG_RISE, ACT_ON_FALL, ACT_TOG_FALL, ACT_STATE, ACT_ON_DELAY,
    ACT_OFF_DELAY, ACT_GROUP_ON, ACT_GROUP_OFF, ACT_VAL_RISE, ACT_VAL_FALL, ACT_VAL_ANY
  };

  int   fail_count   = 0;
  int   queued_reqs  = 0;
  int   cycle_count  = 0;
  int   quiet_cycles = 0;
  int   in_gap       = 0;
  int   stall_left   = 0;
  int   idle_level   = 0;
  logic calm_tail    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // works out the object write (if any) caused by one accepted request
  task automatic predict_object_write(input logic op, input logic lvl, input logic lp);
    logic [ObjNumW-1:0] own_no;
    logic [ObjNumW-1:0] grp_no;
    logic               hit;
    logic               start;
    obj_write_t         wr;
    own_no = ObjNumW'(cfg_chan * 5);
    grp_no = ObjNumW'((cfg_chan / 2) * 10);
    hit = 1'b0;
    start = 1'b0;
    wr.number = own_no;
    wr.value = '0;
    if (op == OP_TICK) begin
      if (timer_on) begin
        if (timer_left > 1) begin
          timer_left = timer_left - 1'b1;
        end else begin
          timer_on = 1'b0;
          timer_left = '0;
          case (cfg_action)
            ACT_ON_DELAY: begin hit = 1'b1; wr.value = 16'd1; end
            ACT_OFF_DELAY: hit = 1'b1;
            ACT_STATE: begin
              start = 1'b1;
              hit = 1'b1;
              wr.value = own_value;
            end
            default: ;
          endcase
        end
      end
    end else if (!lp) begin
      if (lvl) begin
        case (cfg_action)
          ACT_ON_RISE: begin hit = 1'b1; wr.value = ObjValW'(cfg_rising != 0); end
          ACT_TOG_RISE: begin hit = 1'b1; wr.value = ObjValW'(own_value == 0); end
          ACT_GROUP_ON: begin hit = 1'b1; wr.number = grp_no; wr.value = 16'd1; end
          ACT_GROUP_OFF: begin hit = 1'b1; wr.number = grp_no; end
          ACT_STATE: begin
            start = (cfg_delay != 0);
            hit = 1'b1;
            wr.value = cfg_rising;
          end
          ACT_ON_DELAY: start = 1'b1;
          ACT_OFF_DELAY: begin hit = 1'b1; wr.value = 16'd1; end
          ACT_VAL_RISE, ACT_VAL_ANY: begin hit = 1'b1; wr.value = cfg_rising & 16'h00FF; end
          default: ;
        endcase
      end else begin
        case (cfg_action)
          ACT_ON_FALL: begin hit = 1'b1; wr.value = ObjValW'(cfg_falling != 0); end
          ACT_TOG_FALL: begin hit = 1'b1; wr.value = ObjValW'(own_value == 0); end
          ACT_STATE: begin
            start = (cfg_delay != 0);
            hit = 1'b1;
            wr.value = cfg_falling;
          end
          ACT_ON_DELAY: hit = 1'b1;
          ACT_OFF_DELAY: start = 1'b1;
          ACT_VAL_FALL, ACT_VAL_ANY: begin hit = 1'b1; wr.value = cfg_falling & 16'h00FF; end
          default: ;
        endcase
      end
    end
    if (start) begin
      timer_on = 1'b1;
      timer_left = cfg_delay;
    end
    if (hit) begin
      // a group write on an even channel lands on the own object too
      if (wr.number == own_no) own_value = wr.value;
      due_writes.push_back(wr);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    logic         nxt_valid;
    logic         nxt_wr;
    pending_ent_t ent;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) predict_object_write(in_op, in_level, in_long_press);
      if (in_valid || out_valid) quiet_cycles = 0;
      else if (quiet_cycles < QuietCycles) quiet_cycles++;
      nxt_valid = in_valid && in_stall;
      nxt_wr = 1'b0;
      if (!nxt_valid && pending_events.size() != 0) begin
        ent = pending_events[0];
        if (ent.kind == ENT_CFG) begin
          if (quiet_cycles >= QuietCycles) begin
            nxt_wr = 1'b1;
            cfg_index <= ent.reg_idx;
            cfg_wdata <= ent.data;
            case (ent.reg_idx)
              REG_ACTION_CODE:   cfg_action = ent.data[ActionW-1:0];
              REG_RISING_USAGE:  cfg_rising = ent.data[UsageW-1:0];
              REG_FALLING_USAGE: cfg_falling = ent.data[UsageW-1:0];
              REG_DELAY_MS:      cfg_delay = ent.data[DelayW-1:0];
              REG_CHANNEL_INDEX: cfg_chan = ent.data[ChanW-1:0];
              default: ;
            endcase
            void'(pending_events.pop_front());
          end
        end else if (in_gap != 0) begin
          in_gap--;
        end else if (!calm_tail && idle_level != 0 &&
                     $urandom_range(0, 7) < idle_level * 2) begin
          in_gap = $urandom_range(0, 6);
        end else begin
          nxt_valid = 1'b1;
          in_op <= ent.op;
          in_level <= ent.level;
          in_long_press <= ent.long_press;
          void'(pending_events.pop_front());
        end
      end
      in_valid <= nxt_valid;
      cfg_wr_en <= nxt_wr;
      calm_tail <= (pending_events.size() < TailItems);
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin : check_writes
    obj_write_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write object %0d value %h",
                                    out_object_number, out_object_value));
        end else begin
          want = due_writes.pop_front();
          if (out_object_number !== want.number)
            report_mismatch($sformatf("object number %0d, expected %0d",
                                      out_object_number, want.number));
          if (out_object_value !== want.value)
            report_mismatch($sformatf("object value %h, expected %h",
                                      out_object_value, want.value));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm_tail && idle_level != 0 && $urandom_range(0, 7) < idle_level * 2) begin
        stall_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // idling intensity is redrawn at random from the cycle count, level zero gives calm stretches
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) idle_level <= $urandom_range(0, 2);
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_request(input logic op, input logic lvl, input logic lp);
    pending_events.push_back('{ENT_REQ, op, lvl, lp, REG_ACTION_CODE, '0});
    queued_reqs++;
  endtask

  task automatic queue_reg_write(input reg_index_t idx, input logic [CfgDataW-1:0] data);
    pending_events.push_back('{ENT_CFG, OP_LEVEL, 1'b0, 1'b0, idx, data});
  endtask

  // tells whether the latest action code write in this phase is a timer action
  function automatic logic cfg_timer_action(ref pending_ent_t evs[$]);
    logic [ActionW-1:0] code;
    code = '1;
    for (int i = evs.size() - 1; i >= 0; i--) begin
      if (evs[i].kind != ENT_CFG) break;
      if (evs[i].reg_idx == REG_ACTION_CODE) begin
        code = evs[i].data[ActionW-1:0];
        break;
      end
    end
    return (code == ACT_STATE) || (code == ACT_ON_DELAY) || (code == ACT_OFF_DELAY);
  endfunction

  initial begin : stimulus
    int                 pick;
    int                 len;
    int                 tick_pct;
    logic [UsageW-1:0]  usage;
    logic [DelayW-1:0]  dly;

    // reset defaults: send on rising edge, usage zero, channel zero
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_reg_write(REG_RISING_USAGE, CfgDataW'(16'hFFFF));
    queue_reg_write(REG_FALLING_USAGE, CfgDataW'(16'h0000));
    queue_reg_write(REG_CHANNEL_INDEX, CfgDataW'(5'd31));
    queue_request(OP_LEVEL, 1'b1, 1'b1);        // long press is ignored
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_request(OP_TICK, 1'b1, 1'b1);         // tick with the timer stopped
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_TOG_FALL));
    queue_request(OP_LEVEL, 1'b0, 1'b0);
    queue_request(OP_LEVEL, 1'b0, 1'b0);
    // send state: no timer for zero delay, then cyclic repeat
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_STATE));
    queue_reg_write(REG_DELAY_MS, '0);
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_reg_write(REG_DELAY_MS, 26'd2);
    queue_request(OP_LEVEL, 1'b0, 1'b0);
    repeat (4) queue_request(OP_TICK, 1'b0, 1'b0);
    // zero on-delay expires on the next tick
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_ON_DELAY));
    queue_reg_write(REG_DELAY_MS, '0);
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_request(OP_TICK, 1'b0, 1'b0);
    queue_request(OP_LEVEL, 1'b0, 1'b0);
    // group writes: odd channel misses the own object, even channel hits it
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_GROUP_ON));
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_reg_write(REG_CHANNEL_INDEX, CfgDataW'(5'd0));
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_GROUP_OFF));
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_VAL_ANY));
    queue_reg_write(REG_RISING_USAGE, CfgDataW'(16'h1234));
    queue_reg_write(REG_FALLING_USAGE, CfgDataW'(16'hABCD));
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_request(OP_LEVEL, 1'b0, 1'b0);
    // timer keeps running across an action change, expiry on an unused action is silent
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(ACT_ON_DELAY));
    queue_reg_write(REG_DELAY_MS, 26'd1);
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_reg_write(REG_ACTION_CODE, CfgDataW'(9'h1FF));
    queue_request(OP_LEVEL, 1'b1, 1'b0);
    queue_request(OP_TICK, 1'b0, 1'b0);
    queue_request(OP_TICK, 1'b0, 1'b0);
    queue_reg_write(REG_DELAY_MS, 26'h3FFFFFF);

    while (queued_reqs < TotalRequests) begin
      pick = $urandom_range(0, 13);
      queue_reg_write(REG_ACTION_CODE,
                      CfgDataW'((pick < 12) ? action_codes[pick] : ActionW'($urandom)));
      for (int r = 1; r <= 4; r++) begin
        if ($urandom_range(0, 1) == 0) continue;
        case (r)
          1, 2: begin
            pick = $urandom_range(0, 5);
            usage = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : UsageW'($urandom);
            queue_reg_write(reg_index_t'(r), CfgDataW'(usage));
          end
          3: begin
            pick = $urandom_range(0, 9);
            if (pick < 6) dly = DelayW'($urandom_range(0, 4));
            else if (pick < 9) dly = DelayW'($urandom_range(5, 30));
            else dly = ($urandom_range(0, 1) != 0) ? 26'h3FFFFFF : 26'd65535000;
            queue_reg_write(REG_DELAY_MS, dly);
          end
          default: begin
            pick = $urandom_range(0, 3);
            queue_reg_write(REG_CHANNEL_INDEX,
                            CfgDataW'((pick == 0) ? 5'd0 : (pick == 1) ? 5'd31
                                                         : ChanW'($urandom)));
          end
        endcase
      end
      // timer actions get a tick-heavy mix so delays run out
      tick_pct = (pending_events[$].kind == ENT_CFG && cfg_timer_action(pending_events))
                 ? 60 : 25;
      len = $urandom_range(20, 70);
      repeat (len) begin
        if ($urandom_range(0, 99) < tick_pct)
          queue_request(OP_TICK, 1'($urandom), 1'($urandom));
        else
          queue_request(OP_LEVEL, 1'($urandom), ($urandom_range(0, 7) == 0));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_events.size() != 0 || in_valid) @(posedge clk);
    while (due_writes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
